FILE: rtl/core/quaternion_arith_unit_core_assert.svh
// Assertion macros shared by the quaternion arithmetic unit RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef QUATERNION_ARITH_UNIT_CORE_ASSERT_SVH
`define QUATERNION_ARITH_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define QAU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quaternion unit assertion failed");

// Next-cycle implication, disabled while reset is high.
`define QAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quaternion unit assertion failed");

`endif

FILE: rtl/core/qau_pkg.sv
// Shared types and constants of the quaternion arithmetic unit.
// No dependencies; imported by every module of the block.
package qau_pkg;

   localparam int QUAT_COMPS = 4;
   localparam int STAGES     = 6;

   typedef enum logic [2:0] {
      FUNC_ADD  = 3'd0,
      FUNC_MUL  = 3'd1,
      FUNC_CONJ = 3'd2,
      FUNC_NEG  = 3'd3,
      FUNC_ROT  = 3'd4
   } func_type;

   // Hamilton product terms: component k sums the four products a[i]*b[j]
   // listed here as index i*4+j, with the terms flagged in HAM_NEG subtracted.
   localparam logic [3:0] HAM_IDX [QUAT_COMPS][QUAT_COMPS] = '{
      '{4'd0, 4'd5, 4'd10, 4'd15},
      '{4'd1, 4'd4, 4'd11, 4'd14},
      '{4'd2, 4'd7, 4'd8,  4'd13},
      '{4'd3, 4'd6, 4'd9,  4'd12}
   };

   localparam logic [3:0] HAM_NEG [QUAT_COMPS] = '{
      4'b1110, 4'b1000, 4'b0010, 4'b0100
   };

endpackage

FILE: rtl/core/qau_prod.sv
// Registered array of the sixteen component products of two quaternions.
// Depends on qau_pkg.
module qau_prod #(
   parameter int AW = 16,
   parameter int BW = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [AW-1:0]  a_i [qau_pkg::QUAT_COMPS],
   input  logic signed [BW-1:0]  b_i [qau_pkg::QUAT_COMPS],
   output logic signed [AW+BW-1:0] p_o [qau_pkg::QUAT_COMPS*qau_pkg::QUAT_COMPS]
);
   import qau_pkg::*;

   localparam int PW = AW + BW;

   logic signed [PW-1:0] prod_in [QUAT_COMPS*QUAT_COMPS];
   logic signed [PW-1:0] prod_ff [QUAT_COMPS*QUAT_COMPS];

   always_comb begin
      for (int i = 0; i < QUAT_COMPS; i++) begin
         for (int j = 0; j < QUAT_COMPS; j++) begin
            prod_in[i*QUAT_COMPS+j] = PW'(a_i[i]) * PW'(b_i[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign p_o = prod_ff;

endmodule

FILE: rtl/core/qau_rsum.sv
// Hamilton sums of registered products, rounded to nearest and saturated.
// Depends on qau_pkg.
module qau_rsum #(
   parameter int PW       = 32,
   parameter int W        = 16,
   parameter int F        = 14,
   parameter bit VEC_ONLY = 1'b0
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [PW-1:0] p_i [qau_pkg::QUAT_COMPS*qau_pkg::QUAT_COMPS],
   output logic signed [W-1:0]  r_o [qau_pkg::QUAT_COMPS],
   output logic [qau_pkg::QUAT_COMPS-1:0] clamp_o
);
   import qau_pkg::*;

   localparam int SW = PW + 3;
   localparam logic signed [SW-1:0] RND  = SW'(1) <<< (F - 1);
   localparam logic signed [SW-1:0] SMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [SW-1:0] SMIN = ~SMAX;

   logic signed [SW-1:0]    acc [QUAT_COMPS];
   logic signed [SW-1:0]    shr [QUAT_COMPS];
   logic signed [W-1:0]     res_in [QUAT_COMPS];
   logic signed [W-1:0]     res_ff [QUAT_COMPS];
   logic [QUAT_COMPS-1:0]   clamp_in;
   logic [QUAT_COMPS-1:0]   clamp_ff;

   always_comb begin
      for (int k = 0; k < QUAT_COMPS; k++) begin
         acc[k] = RND;
         for (int t = 0; t < QUAT_COMPS; t++) begin
            if (HAM_NEG[k][t]) begin
               acc[k] = acc[k] - SW'(p_i[HAM_IDX[k][t]]);
            end else begin
               acc[k] = acc[k] + SW'(p_i[HAM_IDX[k][t]]);
            end
         end
         shr[k] = acc[k] >>> F;
         if (VEC_ONLY && (k == 0)) begin
            res_in[k]   = '0;
            clamp_in[k] = 1'b0;
         end else if (shr[k] > SMAX) begin
            res_in[k]   = SMAX[W-1:0];
            clamp_in[k] = 1'b1;
         end else if (shr[k] < SMIN) begin
            res_in[k]   = SMIN[W-1:0];
            clamp_in[k] = 1'b1;
         end else begin
            res_in[k]   = shr[k][W-1:0];
            clamp_in[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff   <= res_in;
         clamp_ff <= clamp_in;
      end
   end

   assign r_o     = res_ff;
   assign clamp_o = clamp_ff;

endmodule

FILE: rtl/core/quaternion_arith_unit_core.sv
// Quaternion arithmetic unit: add, Hamilton product, conjugate, negate and
// vector rotation on signed fixed-point components, in a six-stage pipeline.
// Depends on qau_pkg, qau_prod, qau_rsum and quaternion_arith_unit_core_assert.svh.
//
// Usage. A request transaction (req_valid and req_ready both high) carries an
// operation code and quaternion A and B; for rotation B's x, y and z hold the
// vector and B's scalar part is ignored. Every request produces exactly one
// response transaction on the rsp_ channel, in request order, with the four
// result components and a flag that is set when any component saturated.
// rsp_valid rises when the request reaches the output register, where the
// response is taken once rsp_ready is high; the pipeline takes one
// transaction per cycle while the receiver keeps rsp_ready high.
// The stages are: input register, first product array, first rounded sums,
// second product array (rotation only), second rounded sums, output register.
// When the receiver stalls, stages fill up from the output backwards and empty
// stages keep accepting, so req_ready only drops once every stage holds a
// transaction. Nothing is lost or repeated under stall.
// Synchronous reset clears all stage valid bits; data registers are not reset.
// Unused operation codes return zero components with the flag clear.
`include "quaternion_arith_unit_core_assert.svh"

module quaternion_arith_unit_core #(
   parameter int COMP_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [2:0]                   req_func,
   input  logic signed [COMP_WIDTH-1:0] req_aw,
   input  logic signed [COMP_WIDTH-1:0] req_ax,
   input  logic signed [COMP_WIDTH-1:0] req_ay,
   input  logic signed [COMP_WIDTH-1:0] req_az,
   input  logic signed [COMP_WIDTH-1:0] req_bw,
   input  logic signed [COMP_WIDTH-1:0] req_bx,
   input  logic signed [COMP_WIDTH-1:0] req_by_comp,
   input  logic signed [COMP_WIDTH-1:0] req_bz,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COMP_WIDTH-1:0] rsp_rw,
   output logic signed [COMP_WIDTH-1:0] rsp_rx,
   output logic signed [COMP_WIDTH-1:0] rsp_ry,
   output logic signed [COMP_WIDTH-1:0] rsp_rz,
   output logic                         rsp_clamped
);
   import qau_pkg::*;

   localparam int W   = COMP_WIDTH;
   localparam int CW1 = COMP_WIDTH + 1;
   localparam int PW1 = 2 * COMP_WIDTH;
   localparam int PW2 = 2 * COMP_WIDTH + 1;

   // Saturate a value one bit wider than a component; the top bit of the
   // result is the clamp flag.
   function automatic logic [COMP_WIDTH:0] sat_fn(input logic signed [COMP_WIDTH:0] v);
      logic signed [COMP_WIDTH:0] vmax;
      vmax = {2'b00, {(COMP_WIDTH-1){1'b1}}};
      if (v > vmax) begin
         sat_fn = {1'b1, vmax[COMP_WIDTH-1:0]};
      end else if (v < ~vmax) begin
         sat_fn = {1'b1, ~vmax[COMP_WIDTH-1:0]};
      end else begin
         sat_fn = {1'b0, v[COMP_WIDTH-1:0]};
      end
   endfunction

   // Stage handshake: a stage loads when it is empty or its contents move on.
   logic [STAGES-1:0] stage_valid_ff;
   logic [STAGES-1:0] stage_valid_in;
   logic [STAGES-1:0] stage_ready;

   always_comb begin
      stage_ready[STAGES-1] = !stage_valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !stage_valid_ff[k] || stage_ready[k+1];
      end
      stage_valid_in[0] = stage_ready[0] ? req_valid : stage_valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         stage_valid_in[k] = stage_ready[k] ? stage_valid_ff[k-1] : stage_valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = stage_valid_ff[STAGES-1];

   // Stage 0: input register. The scalar part of B is zeroed for rotation so
   // that the vector enters the product as a pure quaternion.
   func_type            s0_func_in, s0_func_ff;
   logic signed [W-1:0] s0_a_in [QUAT_COMPS];
   logic signed [W-1:0] s0_b_in [QUAT_COMPS];
   logic signed [W-1:0] s0_a_ff [QUAT_COMPS];
   logic signed [W-1:0] s0_b_ff [QUAT_COMPS];

   always_comb begin
      s0_func_in = func_type'(req_func);
      s0_a_in[0] = req_aw;
      s0_a_in[1] = req_ax;
      s0_a_in[2] = req_ay;
      s0_a_in[3] = req_az;
      s0_b_in[0] = (s0_func_in == FUNC_ROT) ? '0 : req_bw;
      s0_b_in[1] = req_bx;
      s0_b_in[2] = req_by_comp;
      s0_b_in[3] = req_bz;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         s0_func_ff <= s0_func_in;
         s0_a_ff    <= s0_a_in;
         s0_b_ff    <= s0_b_in;
      end
   end

   // Stage 1: first product array, alongside the exact operations.
   logic signed [PW1-1:0] prod1 [QUAT_COMPS*QUAT_COMPS];

   qau_prod #(.AW(W), .BW(W)) u_prod1 (
      .clock (clock),
      .en    (stage_ready[1]),
      .a_i   (s0_a_ff),
      .b_i   (s0_b_ff),
      .p_o   (prod1)
   );

   func_type            s1_func_ff;
   logic signed [W-1:0] s1_a_ff    [QUAT_COMPS];
   logic signed [W-1:0] s1_side_in [QUAT_COMPS];
   logic signed [W-1:0] s1_side_ff [QUAT_COMPS];
   logic                s1_sflag_in, s1_sflag_ff;
   logic [W:0]          sat_res    [QUAT_COMPS];

   always_comb begin
      s1_sflag_in = 1'b0;
      for (int i = 0; i < QUAT_COMPS; i++) begin
         unique case (s0_func_ff)
            FUNC_ADD: begin
               sat_res[i] = sat_fn(CW1'(s0_a_ff[i]) + CW1'(s0_b_ff[i]));
            end
            FUNC_CONJ: begin
               if (i == 0) begin
                  sat_res[i] = {1'b0, s0_a_ff[i]};
               end else begin
                  sat_res[i] = sat_fn(-CW1'(s0_a_ff[i]));
               end
            end
            FUNC_NEG: begin
               sat_res[i] = sat_fn(-CW1'(s0_a_ff[i]));
            end
            default: begin
               sat_res[i] = '0;
            end
         endcase
         s1_side_in[i] = sat_res[i][W-1:0];
         s1_sflag_in   = s1_sflag_in | sat_res[i][W];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[1]) begin
         s1_func_ff  <= s0_func_ff;
         s1_a_ff     <= s0_a_ff;
         s1_side_ff  <= s1_side_in;
         s1_sflag_ff <= s1_sflag_in;
      end
   end

   // Stage 2: first rounded sums, the product A*B or the intermediate A*v.
   logic signed [W-1:0]   t_q [QUAT_COMPS];
   logic [QUAT_COMPS-1:0] t_clamp;

   qau_rsum #(.PW(PW1), .W(W), .F(FRAC_BITS), .VEC_ONLY(1'b0)) u_rsum1 (
      .clock   (clock),
      .en      (stage_ready[2]),
      .p_i     (prod1),
      .r_o     (t_q),
      .clamp_o (t_clamp)
   );

   func_type            s2_func_ff;
   logic signed [W-1:0] s2_a_ff    [QUAT_COMPS];
   logic signed [W-1:0] s2_side_ff [QUAT_COMPS];
   logic                s2_sflag_ff;

   always_ff @(posedge clock) begin
      if (stage_ready[2]) begin
         s2_func_ff  <= s1_func_ff;
         s2_a_ff     <= s1_a_ff;
         s2_side_ff  <= s1_side_ff;
         s2_sflag_ff <= s1_sflag_ff;
      end
   end

   // Stage 3: second product array against conj(A), kept one bit wider since
   // negating the most negative component is not saturated here. A product
   // result is folded into the side path at this point.
   logic signed [CW1-1:0] conj_op [QUAT_COMPS];
   logic signed [PW2-1:0] prod2   [QUAT_COMPS*QUAT_COMPS];

   always_comb begin
      conj_op[0] = CW1'(s2_a_ff[0]);
      for (int i = 1; i < QUAT_COMPS; i++) begin
         conj_op[i] = -CW1'(s2_a_ff[i]);
      end
   end

   qau_prod #(.AW(W), .BW(CW1)) u_prod2 (
      .clock (clock),
      .en    (stage_ready[3]),
      .a_i   (t_q),
      .b_i   (conj_op),
      .p_o   (prod2)
   );

   func_type            s3_func_ff;
   logic signed [W-1:0] s3_side_in [QUAT_COMPS];
   logic signed [W-1:0] s3_side_ff [QUAT_COMPS];
   logic                s3_sflag_in, s3_sflag_ff;

   always_comb begin
      for (int i = 0; i < QUAT_COMPS; i++) begin
         s3_side_in[i] = (s2_func_ff == FUNC_MUL) ? t_q[i] : s2_side_ff[i];
      end
      s3_sflag_in = ((s2_func_ff == FUNC_MUL) || (s2_func_ff == FUNC_ROT)) ?
                    (|t_clamp) : s2_sflag_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_ready[3]) begin
         s3_func_ff  <= s2_func_ff;
         s3_side_ff  <= s3_side_in;
         s3_sflag_ff <= s3_sflag_in;
      end
   end

   // Stage 4: second rounded sums, vector part only.
   logic signed [W-1:0]   rot_q [QUAT_COMPS];
   logic [QUAT_COMPS-1:0] rot_clamp;

   qau_rsum #(.PW(PW2), .W(W), .F(FRAC_BITS), .VEC_ONLY(1'b1)) u_rsum2 (
      .clock   (clock),
      .en      (stage_ready[4]),
      .p_i     (prod2),
      .r_o     (rot_q),
      .clamp_o (rot_clamp)
   );

   func_type            s4_func_ff;
   logic signed [W-1:0] s4_side_ff [QUAT_COMPS];
   logic                s4_sflag_ff;

   always_ff @(posedge clock) begin
      if (stage_ready[4]) begin
         s4_func_ff  <= s3_func_ff;
         s4_side_ff  <= s3_side_ff;
         s4_sflag_ff <= s3_sflag_ff;
      end
   end

   // Stage 5: output register, choosing the rotation result or the side path.
   logic signed [W-1:0] out_in [QUAT_COMPS];
   logic signed [W-1:0] out_ff [QUAT_COMPS];
   logic                clamped_in, clamped_ff;

   always_comb begin
      if (s4_func_ff == FUNC_ROT) begin
         out_in     = rot_q;
         clamped_in = s4_sflag_ff | (|rot_clamp);
      end else begin
         out_in     = s4_side_ff;
         clamped_in = s4_sflag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[5]) begin
         out_ff     <= out_in;
         clamped_ff <= clamped_in;
      end
   end

   assign rsp_rw      = out_ff[0];
   assign rsp_rx      = out_ff[1];
   assign rsp_ry      = out_ff[2];
   assign rsp_rz      = out_ff[3];
   assign rsp_clamped = clamped_ff;

   // A transaction moving from stage 4 into the output register, and whether
   // its operation code is one of the unused ones.
   logic s4_take;
   logic s4_spare;

   assign s4_take  = stage_valid_ff[4] && stage_ready[5];
   assign s4_spare = (s4_func_ff != FUNC_ADD) && (s4_func_ff != FUNC_MUL) &&
                     (s4_func_ff != FUNC_CONJ) && (s4_func_ff != FUNC_NEG) &&
                     (s4_func_ff != FUNC_ROT);

   // A free output register or a taking receiver must let a request in.
   `QAU_ASSERT_SAME(a_ready_chain, clock, reset, stage_ready[STAGES-1], req_ready)
   // A transaction held in stage 4 under a stall is still there next cycle.
   `QAU_ASSERT_NEXT(a_stage4_hold, clock, reset, (stage_valid_ff[4] && !s4_take), stage_valid_ff[4])
   // A rotation leaves the scalar part of the response at zero.
   `QAU_ASSERT_NEXT(a_rot_scalar, clock, reset, (s4_take && (s4_func_ff == FUNC_ROT)), (rsp_rw == '0))
   // Unused operation codes produce an all-zero response; x and the flag are checked.
   `QAU_ASSERT_NEXT(a_unused_zero, clock, reset, (s4_take && s4_spare), (rsp_rx == '0) && !rsp_clamped)

endmodule
